// File: hdl/erc_pkg.sv
package erc_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    localparam int LEN_W       = 32;
    localparam int OFFSET_W    = 48;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 48;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 88;
    localparam int ENTRY_W     = LEN_W + 1;

    localparam logic [LEN_W-1:0] RESET_REQUEST_LIMIT = LEN_W'(1024 * 1024);
    localparam logic [LEN_W-1:0] RESET_ZERO_LIMIT    = LEN_W'(128 * 1024 * 1024);

    localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_LIMIT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_LIMIT    = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_CAN_ZERO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_SIZE    = CFG_INDEX_W'(3);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_NEXT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_DONE  = 2'd3
    } status_t;

endpackage

// File: hdl/erc_ram.sv
module erc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/extent_request_chunker.sv
// A load item gives its result in the cycle after it is accepted.
// A next item runs through the check, limit, walk and finish states; each stored extent that it
// reads needs one read of the extent memory and one compare/subtract step.
// A next item on a finished copy or an empty table is answered from the check state, with no walk.
// One item is in work at a time. Synchronous active-low reset empties the extent table,
// zeroes the copy offset and restores the register defaults; the memory is not cleared.
module extent_request_chunker
    import erc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // extent_length, extent_zero, zero fill
    input  logic                   s_tuser,   // kind

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // req_offset, req_length, req_zero, zero fill
    output logic                   m_tlast,
    output logic [STATUS_W-1:0]    m_tuser,   // status

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LIMIT,
        ST_WALK,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ADDR_W-1:0]    rpos_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [LEN_W-1:0]     request_limit_reg;
    logic [LEN_W-1:0]     zero_limit_reg;
    logic                 dest_can_zero_reg;
    logic [OFFSET_W-1:0]  total_size_reg;

    logic [ADDR_W-1:0]    pos_reg;
    logic                 is_zero_reg;
    logic [OFFSET_W-1:0]  remaining_reg;
    logic [LEN_W-1:0]     limit_reg;
    logic [LEN_W-1:0]     room_reg;
    logic [LEN_W-1:0]     length_reg;
    logic [LEN_W-1:0]     pos_len_reg;

    logic                 m_tvalid_reg;
    logic [OFFSET_W-1:0]  m_offset_reg;
    logic [LEN_W-1:0]     m_length_reg;
    logic                 m_zero_reg;
    logic                 m_last_reg;
    status_t              m_status_reg;

    logic                 s_accept;
    logic                 table_full;
    logic [ADDR_W-1:0]    start_pos;
    logic [OFFSET_W:0]    size_diff;
    logic                 copy_done;
    logic [LEN_W-1:0]     sel_limit;
    logic [LEN_W-1:0]     limit_next;
    logic [LEN_W-1:0]     rd_len;
    logic                 rd_zero;
    logic                 walk_stop;
    logic                 walk_split;
    logic                 pos_last;
    logic                 drained;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    assign s_tready   = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign table_full = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign start_pos  = ({1'b0, rpos_reg} >= cnt_reg) ? '0 : rpos_reg;
    assign size_diff  = {1'b0, total_size_reg} - {1'b0, offset_reg};
    assign copy_done  = size_diff[OFFSET_W] || (size_diff[OFFSET_W-1:0] == '0);

    assign sel_limit  = (is_zero_reg && dest_can_zero_reg) ? zero_limit_reg : request_limit_reg;
    assign limit_next = (remaining_reg < {{(OFFSET_W-LEN_W){1'b0}}, sel_limit})
                        ? remaining_reg[LEN_W-1:0] : sel_limit;

    assign rd_len     = ram_rdata[LEN_W-1:0];
    assign rd_zero    = ram_rdata[LEN_W];
    assign walk_stop  = (rd_zero != is_zero_reg) || (room_reg == '0);
    assign walk_split = rd_len > room_reg;
    assign pos_last   = (({1'b0, pos_reg} + CNT_W'(1)) >= cnt_reg);
    assign drained    = pos_last && (pos_len_reg == '0);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = {is_zero_reg, (walk_split ? (rd_len - room_reg) : '0)};
        if ((state_reg == ST_IDLE) && s_accept && (s_tuser == KIND_LOAD) && !table_full) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[ADDR_W-1:0];
            ram_wdata = s_tdata[ENTRY_W-1:0];
        end else if ((state_reg == ST_WALK) && !walk_stop) begin
            ram_we    = 1'b1;
        end
    end

    assign ram_raddr = (state_reg == ST_IDLE) ? start_pos : pos_reg;

    erc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_extent_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            rpos_reg          <= '0;
            offset_reg        <= '0;
            request_limit_reg <= RESET_REQUEST_LIMIT;
            zero_limit_reg    <= RESET_ZERO_LIMIT;
            dest_can_zero_reg <= 1'b1;
            total_size_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !(s_accept && (s_tuser == KIND_LOAD))) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    CFG_REQUEST_LIMIT: request_limit_reg <= cfg_data[LEN_W-1:0];
                    CFG_ZERO_LIMIT:    zero_limit_reg    <= cfg_data[LEN_W-1:0];
                    CFG_DEST_CAN_ZERO: dest_can_zero_reg <= cfg_data[0];
                    CFG_TOTAL_SIZE:    total_size_reg    <= cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser == KIND_LOAD) begin
                            m_tvalid_reg <= 1'b1;
                            m_offset_reg <= '0;
                            m_length_reg <= '0;
                            m_zero_reg   <= 1'b0;
                            m_last_reg   <= 1'b0;
                            m_status_reg <= table_full ? STATUS_FULL : STATUS_OK;
                            if (!table_full) begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                        end else begin
                            pos_reg   <= start_pos;
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (copy_done || (cnt_reg == '0)) begin
                        m_tvalid_reg <= 1'b1;
                        m_offset_reg <= '0;
                        m_length_reg <= '0;
                        m_zero_reg   <= 1'b0;
                        m_last_reg   <= 1'b0;
                        m_status_reg <= copy_done ? STATUS_DONE : STATUS_EMPTY;
                        state_reg    <= ST_IDLE;
                    end else begin
                        remaining_reg <= size_diff[OFFSET_W-1:0];
                        is_zero_reg   <= rd_zero;
                        state_reg     <= ST_LIMIT;
                    end
                end
                ST_LIMIT: begin
                    limit_reg  <= limit_next;
                    room_reg   <= limit_next;
                    length_reg <= '0;
                    state_reg  <= ST_WALK;
                end
                ST_WALK: begin
                    if (walk_stop) begin
                        pos_len_reg <= rd_len;
                        state_reg   <= ST_FINISH;
                    end else if (walk_split) begin
                        length_reg  <= length_reg + room_reg;
                        room_reg    <= '0;
                        pos_len_reg <= rd_len - room_reg;
                        state_reg   <= ST_FINISH;
                    end else begin
                        length_reg <= length_reg + rd_len;
                        room_reg   <= room_reg - rd_len;
                        if (pos_last) begin
                            pos_len_reg <= '0;
                            state_reg   <= ST_FINISH;
                        end else begin
                            pos_reg   <= pos_reg + ADDR_W'(1);
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: begin
                    state_reg <= ST_WALK;
                end
                ST_FINISH: begin
                    offset_reg   <= offset_reg + {{(OFFSET_W-LEN_W){1'b0}}, length_reg};
                    m_tvalid_reg <= 1'b1;
                    m_offset_reg <= offset_reg;
                    m_length_reg <= length_reg;
                    m_zero_reg   <= is_zero_reg;
                    m_last_reg   <= drained;
                    m_status_reg <= STATUS_OK;
                    if (drained) begin
                        cnt_reg  <= '0;
                        rpos_reg <= '0;
                    end else begin
                        rpos_reg <= pos_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-OFFSET_W-LEN_W-1){1'b0}}, m_zero_reg, m_length_reg,
                       m_offset_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("extent count exceeds the table depth");

    a_empty_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (rpos_reg == '0))
        else $error("read position not rewound on an empty table");

    a_rpos_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> ({1'b0, rpos_reg} < cnt_reg))
        else $error("read position beyond the stored extents");

    a_length_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) || (state_reg == ST_WAIT) || (state_reg == ST_FINISH))
        |-> (({1'b0, length_reg} + {1'b0, room_reg}) == {1'b0, limit_reg}))
        else $error("request length and room do not add up to the limit");

    a_status_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg != STATUS_OK)) |-> ((m_length_reg == '0) && !m_last_reg))
        else $error("non-ok status item carries a request");

endmodule
